/* rtl/dust_median_batch_monitor_macros.svh */
// Assertion macros for the dust median batch monitor checker.
// Included by the checker file only; holds no logic of its own.
`ifndef DUST_MEDIAN_BATCH_MONITOR_MACROS_SVH
`define DUST_MEDIAN_BATCH_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DBM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DBM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/dbm_pkg.sv */
// Shared types and constants of the dust median batch monitor.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package dbm_pkg;

   // Default window length and failure limit for the top-level parameters.
   localparam int DBM_WINDOW     = 5;
   localparam int DBM_FAIL_LIMIT = 3;

   // Fixed field widths.
   localparam int ADC_BITS   = 12;
   localparam int DENS_BITS  = 24;
   localparam int MS_BITS    = 32;
   localparam int GAIN_BITS  = 32;
   localparam int OFS_BITS   = 40;
   localparam int MINV_BITS  = 5;
   localparam int CNT_BITS   = 32;
   localparam int STRK_BITS  = 8;
   localparam int PROD_BITS  = ADC_BITS + GAIN_BITS;
   localparam int SUM_BITS   = PROD_BITS + 2;
   localparam int CSR_IDX_W  = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RAIL_LOW      = 3'd0,
      CSR_RAIL_HIGH     = 3'd1,
      CSR_VOLTAGE_LIMIT = 3'd2,
      CSR_MIN_VALID     = 3'd3,
      CSR_STALE_TIMEOUT = 3'd4,
      CSR_DENSITY_GAIN  = 3'd5,
      CSR_DENSITY_OFS   = 3'd6,
      CSR_MAX_DENSITY   = 3'd7
   } csr_index_type;

   // Input item modes.
   typedef enum logic {
      MODE_SAMPLE     = 1'b0,
      MODE_TIME_CHECK = 1'b1
   } mode_type;

   // One input word.
   typedef struct packed {
      mode_type               mode;
      logic [ADC_BITS-1:0]    raw_adc;
      logic                   timing_ok;
      logic [MS_BITS-1:0]     now_ms;
   } req_type;

   // One result word.
   typedef struct packed {
      logic                   batch_done;
      logic [DENS_BITS-1:0]   density;
      logic [ADC_BITS-1:0]    median_raw;
      logic                   online;
      logic                   abnormal;
      logic                   saturated;
      logic [CNT_BITS-1:0]    good_batches;
      logic [CNT_BITS-1:0]    bad_batches;
   } rsp_type;

   // One stored sample of the window.
   typedef struct packed {
      logic                   timing;
      logic [ADC_BITS-1:0]    raw;
   } sample_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_ADD,
      ST_JUDGE,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic scan;
      logic mul;
      logic add;
      logic judge;
      logic load_rsp;
      logic batch_done;
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/dbm_ctrl.sv */
// Controller of the dust median batch monitor: state machine, fill and scan
// counters and the result valid flag. Depends on dbm_pkg.
`default_nettype none

module dbm_ctrl #(
   parameter int WINDOW = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire dbm_pkg::mode_type req_mode,
   output logic                  req_ready,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output dbm_pkg::cmd_type      cmd
);
   import dbm_pkg::*;

   localparam int CNT_W = $clog2(WINDOW + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             batch_ff, batch_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             fill_last;
   logic             scan_last;
   logic             slot_free;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign fill_last = (fill_ff == CNT_W'(WINDOW - 1));
   assign scan_last = (scan_ff == CNT_W'(WINDOW - 1));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_mode == MODE_SAMPLE) && fill_last) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_ADD;
         ST_ADD:   state_in = ST_JUDGE;
         ST_JUDGE: state_in = ST_OUT;
         ST_OUT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      cmd.capture    = accept;
      cmd.scan       = (state_ff == ST_SCAN);
      cmd.mul        = (state_ff == ST_MUL);
      cmd.add        = (state_ff == ST_ADD);
      cmd.judge      = (state_ff == ST_JUDGE);
      cmd.load_rsp   = (state_ff == ST_OUT) && slot_free;
      cmd.batch_done = batch_ff;
   end

   // Window fill count, scan count and the result valid flag.
   always_comb begin
      fill_in      = fill_ff;
      batch_in     = batch_ff;
      scan_in      = '0;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         batch_in = 1'b0;
         if (req_mode == MODE_SAMPLE) begin
            batch_in = fill_last;
            fill_in  = fill_last ? '0 : fill_ff + 1'b1;
         end
      end
      if (state_ff == ST_SCAN) begin
         scan_in = scan_ff + 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         scan_ff      <= '0;
         batch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         batch_ff     <= batch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/dbm_datapath.sv */
// Datapath of the dust median batch monitor: configuration registers, sample
// window, rank scan, calibration multiply and status. Depends on dbm_pkg.
`default_nettype none

module dbm_datapath #(
   parameter int WINDOW     = 5,
   parameter int FAIL_LIMIT = 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dbm_pkg::cmd_type        cmd,
   input  wire dbm_pkg::req_type        req_data,
   input  wire logic                    csr_write,
   input  wire dbm_pkg::csr_index_type  csr_index,
   input  wire logic [dbm_pkg::OFS_BITS-1:0] csr_data,
   output dbm_pkg::rsp_type             rsp_data
);
   import dbm_pkg::*;

   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int RANK  = WINDOW / 2;

   // Configuration registers.
   logic [ADC_BITS-1:0]        rail_low_ff;
   logic [ADC_BITS-1:0]        rail_high_ff;
   logic [ADC_BITS-1:0]        vlim_ff;
   logic [MINV_BITS-1:0]       min_valid_ff;
   logic [MS_BITS-1:0]         stale_ff;
   logic [GAIN_BITS-1:0]       gain_ff;
   logic signed [OFS_BITS-1:0] offset_ff;
   logic [DENS_BITS-1:0]       max_dens_ff;

   // Window and batch working registers.
   sample_type                 window_ff [WINDOW];
   logic [MS_BITS-1:0]         now_ff;
   logic [CNT_W-1:0]           valid_cnt_ff;
   logic                       sat_ff;
   logic [ADC_BITS-1:0]        med_ff;
   logic [PROD_BITS-1:0]       prod_ff;
   logic signed [SUM_BITS-1:0] sum_ff;

   // Status registers and their next values.
   logic [STRK_BITS-1:0]       fail_ff, fail_in;
   logic [MS_BITS-1:0]         last_good_ff, last_good_in;
   logic                       ever_good_ff, ever_good_in;
   logic                       online_ff, online_in;
   logic                       abnormal_ff, abnormal_in;
   logic                       saturated_ff, saturated_in;
   logic [DENS_BITS-1:0]       held_dens_ff, held_dens_in;
   logic [ADC_BITS-1:0]        held_med_ff, held_med_in;
   logic [CNT_BITS-1:0]        good_ff, good_in;
   logic [CNT_BITS-1:0]        bad_ff, bad_in;
   rsp_type                    rsp_ff;

   // Combinational helpers.
   sample_type                 tap;
   logic [CNT_W-1:0]           cnt_lt;
   logic [CNT_W-1:0]           cnt_le;
   logic                       is_median;
   logic [MS_BITS-1:0]         elapsed;
   logic                       stale;
   logic                       med_ok;
   logic                       reject_basic;
   logic                       negative;
   logic                       over;
   logic                       reject_any;
   logic [DENS_BITS-1:0]       dens_val;
   logic [STRK_BITS-1:0]       fail_inc;

   function automatic logic at_rail(input logic [ADC_BITS-1:0] raw,
                                    input logic [ADC_BITS-1:0] lo,
                                    input logic [ADC_BITS-1:0] hi);
      return (raw <= lo) || (raw >= hi);
   endfunction

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rail_low_ff  <= '0;
         rail_high_ff <= '1;
         vlim_ff      <= '1;
         min_valid_ff <= MINV_BITS'(3);
         stale_ff     <= MS_BITS'(5000);
         gain_ff      <= GAIN_BITS'(65536);
         offset_ff    <= '0;
         max_dens_ff  <= '1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RAIL_LOW:      rail_low_ff  <= csr_data[ADC_BITS-1:0];
            CSR_RAIL_HIGH:     rail_high_ff <= csr_data[ADC_BITS-1:0];
            CSR_VOLTAGE_LIMIT: vlim_ff      <= csr_data[ADC_BITS-1:0];
            CSR_MIN_VALID:     min_valid_ff <= csr_data[MINV_BITS-1:0];
            CSR_STALE_TIMEOUT: stale_ff     <= csr_data[MS_BITS-1:0];
            CSR_DENSITY_GAIN:  gain_ff      <= csr_data[GAIN_BITS-1:0];
            CSR_DENSITY_OFS:   offset_ff    <= $signed(csr_data);
            CSR_MAX_DENSITY:   max_dens_ff  <= csr_data[DENS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Rank of the candidate at the last tap against the whole window.
   assign tap = window_ff[WINDOW-1];

   always_comb begin
      cnt_lt = '0;
      cnt_le = '0;
      for (int i = 0; i < WINDOW; i++) begin
         if (window_ff[i].raw < tap.raw) begin
            cnt_lt = cnt_lt + 1'b1;
         end
         if (window_ff[i].raw <= tap.raw) begin
            cnt_le = cnt_le + 1'b1;
         end
      end
   end

   // The candidate is the median when it can sit at the middle sorted place.
   assign is_median = (cnt_lt <= CNT_W'(RANK)) && (cnt_le > CNT_W'(RANK));

   // Window shift on a new sample, rotation during the scan.
   always_ff @(posedge clock) begin
      if (cmd.capture && (req_data.mode == MODE_SAMPLE)) begin
         window_ff[0] <= '{timing: req_data.timing_ok, raw: req_data.raw_adc};
         for (int i = 1; i < WINDOW; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
      end else if (cmd.scan) begin
         window_ff[0] <= window_ff[WINDOW-1];
         for (int i = 1; i < WINDOW; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
      end
   end

   // Batch accumulators, median, product and calibrated sum.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff       <= req_data.now_ms;
         valid_cnt_ff <= '0;
         sat_ff       <= 1'b0;
      end
      if (cmd.scan) begin
         if (tap.timing && !at_rail(tap.raw, rail_low_ff, rail_high_ff) &&
             (tap.raw <= vlim_ff)) begin
            valid_cnt_ff <= valid_cnt_ff + 1'b1;
         end
         if (at_rail(tap.raw, rail_low_ff, rail_high_ff)) begin
            sat_ff <= 1'b1;
         end
         if (is_median) begin
            med_ff <= tap.raw;
         end
      end
      if (cmd.mul) begin
         prod_ff <= PROD_BITS'(med_ff) * PROD_BITS'(gain_ff);
      end
      if (cmd.add) begin
         sum_ff <= $signed({2'b00, prod_ff}) + SUM_BITS'(offset_ff);
      end
   end

   // Stale check on every accepted word.
   assign elapsed = req_data.now_ms - last_good_ff;
   assign stale   = online_ff && (elapsed > stale_ff);

   // Batch verdict.
   assign med_ok       = !at_rail(med_ff, rail_low_ff, rail_high_ff) && (med_ff <= vlim_ff);
   assign reject_basic = ((MINV_BITS + 1)'(valid_cnt_ff) < (MINV_BITS + 1)'(min_valid_ff)) ||
                         !med_ok;
   assign negative     = sum_ff[SUM_BITS-1];
   assign over         = !negative &&
                         (sum_ff[SUM_BITS-2:16] > (SUM_BITS - 17)'(max_dens_ff));
   assign reject_any   = reject_basic || over;
   assign dens_val     = negative ? '0 : sum_ff[DENS_BITS+15:16];
   assign fail_inc     = (fail_ff == '1) ? fail_ff : fail_ff + 1'b1;

   // Status next values.
   always_comb begin
      fail_in      = fail_ff;
      last_good_in = last_good_ff;
      ever_good_in = ever_good_ff;
      online_in    = online_ff;
      abnormal_in  = abnormal_ff;
      saturated_in = saturated_ff;
      held_dens_in = held_dens_ff;
      held_med_in  = held_med_ff;
      good_in      = good_ff;
      bad_in       = bad_ff;
      if (cmd.capture && stale) begin
         online_in   = 1'b0;
         abnormal_in = 1'b1;
      end
      if (cmd.judge) begin
         if (reject_any) begin
            bad_in       = bad_ff + 1'b1;
            abnormal_in  = 1'b1;
            saturated_in = reject_basic ? sat_ff : 1'b0;
            fail_in      = fail_inc;
            if (!ever_good_ff || (fail_inc >= STRK_BITS'(FAIL_LIMIT))) begin
               online_in = 1'b0;
            end
         end else begin
            held_dens_in = dens_val;
            held_med_in  = med_ff;
            online_in    = 1'b1;
            abnormal_in  = 1'b0;
            saturated_in = 1'b0;
            last_good_in = now_ff;
            good_in      = good_ff + 1'b1;
            fail_in      = '0;
            ever_good_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_ff      <= '0;
         last_good_ff <= '0;
         ever_good_ff <= 1'b0;
         online_ff    <= 1'b0;
         abnormal_ff  <= 1'b0;
         saturated_ff <= 1'b0;
         held_dens_ff <= '0;
         held_med_ff  <= '0;
         good_ff      <= '0;
         bad_ff       <= '0;
      end else begin
         fail_ff      <= fail_in;
         last_good_ff <= last_good_in;
         ever_good_ff <= ever_good_in;
         online_ff    <= online_in;
         abnormal_ff  <= abnormal_in;
         saturated_ff <= saturated_in;
         held_dens_ff <= held_dens_in;
         held_med_ff  <= held_med_in;
         good_ff      <= good_in;
         bad_ff       <= bad_in;
      end
   end

   // Result register, loaded once the status has settled.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.batch_done   <= cmd.batch_done;
         rsp_ff.density      <= held_dens_ff;
         rsp_ff.median_raw   <= held_med_ff;
         rsp_ff.online       <= online_ff;
         rsp_ff.abnormal     <= abnormal_ff;
         rsp_ff.saturated    <= saturated_ff;
         rsp_ff.good_batches <= good_ff;
         rsp_ff.bad_batches  <= bad_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* rtl/dust_median_batch_monitor.sv */
// Dust sensor batch median monitor.
// A sample word (mode sample) enters the window; a time-check word only runs
// the stale check. Every accepted word gives exactly one result word with the
// held density, median, status flags and batch counters; batch_done marks the
// word that filled the window.
// Channels: req_ and rsp_ use valid/ready; csr_ writes a configuration
// register by index and is always ready. Write it only while the block is idle.
// A word that does not close a batch goes straight to loading its result;
// the word that closes a batch first runs the rank scan, which tests one
// window entry per cycle, then the calibration multiply, the offset add and
// the verdict.
// One word is in flight at a time; the next is accepted the cycle after its
// result is loaded into the output register, which then waits for rsp_ready.
// If the receiver stalls, the result holds and the block stops before loading
// the next one. Reset clears all status, counters and configuration to their
// defaults; the sample window needs no clearing.
`default_nettype none

module dust_median_batch_monitor #(
   parameter int WINDOW     = dbm_pkg::DBM_WINDOW,
   parameter int FAIL_LIMIT = dbm_pkg::DBM_FAIL_LIMIT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire dbm_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output dbm_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire dbm_pkg::csr_index_type       csr_index,
   input  wire logic [dbm_pkg::OFS_BITS-1:0] csr_data
);
   import dbm_pkg::*;

   cmd_type cmd;

   // Configuration writes are always accepted and are registered.
   assign csr_ready = 1'b1;

   dbm_ctrl #(
      .WINDOW (WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   dbm_datapath #(
      .WINDOW     (WINDOW),
      .FAIL_LIMIT (FAIL_LIMIT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/dbm_checker.sv */
// Port-level checker for the dust median batch monitor and its bind.
// Depends on dbm_pkg and the assertion macros header.
`default_nettype none

`include "dust_median_batch_monitor_macros.svh"

module dbm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire dbm_pkg::rsp_type rsp_data
);

   // A stalled result word holds its value.
   `DBM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // Only a rejected batch sets saturated, and it always sets abnormal too.
   `DBM_ASSERT_IMP(a_sat_abnormal, clock, reset, rsp_valid && rsp_data.saturated, rsp_data.abnormal, "saturated without abnormal")

   // Only one word is worked on at a time.
   `DBM_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "word accepted while busy")

endmodule

bind dust_median_batch_monitor dbm_checker u_checker (.*);

`default_nettype wire
